// ----- src/cpct_pkg.sv -----
`default_nettype none

package cpct_pkg;

  localparam int SINE_BITS     = 16;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 16;

  localparam int          INV_SQRT3_Q16  = 37837;
  localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
  localparam logic [63:0] SINE_AMPLITUDE = 64'd32767;

  typedef enum logic [1:0] {
    PHASE_ALL_SENSED = 2'd0,
    PHASE_A_MISSING  = 2'd1,
    PHASE_B_MISSING  = 2'd2,
    PHASE_C_MISSING  = 2'd3
  } phase_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MISSING_PHASE     = 4'd0,
    CFG_POLE_COUNT        = 4'd1,
    CFG_REVERSE_DIRECTION = 4'd2,
    CFG_ZERO_OFFSET       = 4'd3
  } cfg_index_e;

  typedef struct packed {
    phase_e      missing_phase;
    logic [6:0]  pole_count;
    logic        reverse_direction;
    logic [15:0] zero_offset;
  } cfg_t;

  localparam phase_e      MISSING_PHASE_RST = PHASE_C_MISSING;
  localparam logic [6:0]  POLE_COUNT_RST    = 7'd1;
  localparam logic        REVERSE_RST       = 1'b0;
  localparam logic [15:0] ZERO_OFFSET_RST   = 16'd0;

  // per-stage load strobes
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_ld_t;

  // alpha after phase rebuild
  function automatic int alpha_width(input int current_bits);
    return current_bits + 2;
  endfunction

  // beta sum carries three more bits, beta scaled by 1/sqrt3 seventeen more
  function automatic int beta_sum_width(input int current_bits);
    return current_bits + 3;
  endfunction

  function automatic int beta_width(input int current_bits);
    return current_bits + 20;
  endfunction

endpackage

`default_nettype wire

// ----- src/cpct_if.sv -----
`default_nettype none

interface cpct_in_if #(
  parameter int CURRENT_BITS = 16,
  parameter int ANGLE_BITS   = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [CURRENT_BITS-1:0] ia_current;
  logic signed [CURRENT_BITS-1:0] ib_current;
  logic signed [CURRENT_BITS-1:0] ic_current;
  logic        [ANGLE_BITS-1:0]   rotor_pos;

  modport source (output valid, ia_current, ib_current, ic_current, rotor_pos, input ready);
  modport sink   (input valid, ia_current, ib_current, ic_current, rotor_pos, output ready);
endinterface

interface cpct_out_if #(
  parameter int CURRENT_BITS = 16,
  parameter int ANGLE_BITS   = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [CURRENT_BITS-1:0] d_current;
  logic signed [CURRENT_BITS-1:0] q_current;
  logic        [ANGLE_BITS-1:0]   electrical_angle;
  logic                           saturated;

  modport source (output valid, d_current, q_current, electrical_angle, saturated, input ready);
  modport sink   (input valid, d_current, q_current, electrical_angle, saturated, output ready);
endinterface

interface cpct_cfg_if
  import cpct_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/cpct_angle.sv -----
`default_nettype none

module cpct_angle
  import cpct_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk_i,
  input  cfg_t                  cfg_i,
  input  stage_ld_t             ld_i,
  input  logic [ANGLE_BITS-1:0] rotor_pos_i,
  output logic [ANGLE_BITS-1:0] eangle1_o,
  output logic [ANGLE_BITS-1:0] eangle4_o
);

  localparam int PW = ANGLE_BITS + 7;

  logic [ANGLE_BITS-1:0] shaft_dir;
  logic [PW-1:0]         prod;
  logic [ANGLE_BITS-1:0] eangle_d;
  logic [ANGLE_BITS-1:0] eangle1_q, eangle2_q, eangle3_q, eangle4_q;

  always_comb begin
    shaft_dir = cfg_i.reverse_direction ? ('0 - rotor_pos_i) : rotor_pos_i;
    prod      = PW'(shaft_dir) * PW'(cfg_i.pole_count);
    eangle_d  = prod[ANGLE_BITS-1:0] - ANGLE_BITS'(cfg_i.zero_offset);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s1) eangle1_q <= eangle_d;
    if (ld_i.s2) eangle2_q <= eangle1_q;
    if (ld_i.s3) eangle3_q <= eangle2_q;
    if (ld_i.s4) eangle4_q <= eangle3_q;
  end

  assign eangle1_o = eangle1_q;
  assign eangle4_o = eangle4_q;

endmodule

`default_nettype wire

// ----- src/cpct_clarke.sv -----
`default_nettype none

module cpct_clarke
  import cpct_pkg::*;
#(
  parameter int CURRENT_BITS = 16
) (
  input  logic                                         clk_i,
  input  cfg_t                                         cfg_i,
  input  stage_ld_t                                    ld_i,
  input  logic signed [CURRENT_BITS-1:0]               ia_current_i,
  input  logic signed [CURRENT_BITS-1:0]               ib_current_i,
  input  logic signed [CURRENT_BITS-1:0]               ic_current_i,
  output logic signed [alpha_width(CURRENT_BITS)-1:0]  alpha2_o,
  output logic signed [beta_width(CURRENT_BITS)-1:0]   beta2_o
);

  localparam int AW  = alpha_width(CURRENT_BITS);
  localparam int BSW = beta_sum_width(CURRENT_BITS);
  localparam int BWW = beta_width(CURRENT_BITS);
  localparam logic signed [BWW-1:0] INV_SQRT3 = BWW'(INV_SQRT3_Q16);

  logic signed [AW-1:0]  ia_x, ib_x, ic_x;
  logic signed [AW-1:0]  alpha_d, b_phase;
  logic signed [BSW-1:0] beta_sum_d;
  logic signed [AW-1:0]  alpha1_q, alpha2_q;
  logic signed [BSW-1:0] beta_sum1_q;
  logic signed [BWW-1:0] beta2_q;

  always_comb begin
    ia_x = AW'(ia_current_i);
    ib_x = AW'(ib_current_i);
    ic_x = AW'(ic_current_i);
    case (cfg_i.missing_phase)
      PHASE_A_MISSING: begin
        alpha_d = -(ib_x + ic_x);
        b_phase = ib_x;
      end
      PHASE_B_MISSING: begin
        alpha_d = ia_x;
        b_phase = -(ia_x + ic_x);
      end
      default: begin
        alpha_d = ia_x;
        b_phase = ib_x;
      end
    endcase
    if (cfg_i.missing_phase == PHASE_ALL_SENSED) begin
      beta_sum_d = BSW'(ib_x) - BSW'(ic_x);
    end else begin
      beta_sum_d = BSW'(alpha_d) + (BSW'(b_phase) <<< 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s1) begin
      alpha1_q    <= alpha_d;
      beta_sum1_q <= beta_sum_d;
    end
    if (ld_i.s2) begin
      alpha2_q <= alpha1_q;
      beta2_q  <= BWW'(beta_sum1_q) * INV_SQRT3;
    end
  end

  assign alpha2_o = alpha2_q;
  assign beta2_o  = beta2_q;

endmodule

`default_nettype wire

// ----- src/cpct_sine.sv -----
`default_nettype none

module cpct_sine
  import cpct_pkg::*;
#(
  parameter int SINE_INDEX_BITS = 10,
  parameter int ANGLE_BITS      = 16
) (
  input  logic                        clk_i,
  input  stage_ld_t                   ld_i,
  input  logic [ANGLE_BITS-1:0]       eangle_i,
  output logic signed [SINE_BITS-1:0] sin2_o,
  output logic signed [SINE_BITS-1:0] cos2_o
);

  localparam int QBITS = SINE_INDEX_BITS - 2;
  localparam int Q     = 1 << QBITS;
  localparam int RAW   = QBITS + 1;

  logic [SINE_BITS-1:0] rom [Q+1];

  // quarter-wave entry by taylor series in q30
  for (genvar j = 0; j <= Q; j++) begin : g_rom
    localparam logic [63:0] X  = (HALF_PI_Q30 * 64'(j)) >> QBITS;
    localparam logic [63:0] X2 = (X * X) >> 30;
    localparam logic [63:0] T1 = ((X  * X2) >> 30) / 64'd6;
    localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
    localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
    localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
    localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
    localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 64'd156;
    localparam logic [63:0] T7 = ((T6 * X2) >> 30) / 64'd210;
    localparam logic [63:0] T8 = ((T7 * X2) >> 30) / 64'd272;
    localparam logic signed [63:0] SUM = signed'(X) - signed'(T1) + signed'(T2)
                                       - signed'(T3) + signed'(T4) - signed'(T5)
                                       + signed'(T6) - signed'(T7) + signed'(T8);
    localparam logic [63:0] POS = (SUM < 0) ? 64'd0 : unsigned'(SUM);
    localparam logic [63:0] R   = (POS * SINE_AMPLITUDE + (64'd1 << 29)) >> 30;
    localparam logic [SINE_BITS-1:0] ENTRY =
      SINE_BITS'((R > SINE_AMPLITUDE) ? SINE_AMPLITUDE : R);
    assign rom[j] = ENTRY;
  end

  logic [SINE_INDEX_BITS-1:0] sin_idx, cos_idx;

  if (ANGLE_BITS >= SINE_INDEX_BITS) begin : g_idx_trunc
    assign sin_idx = eangle_i[ANGLE_BITS-1 -: SINE_INDEX_BITS];
  end else begin : g_idx_widen
    assign sin_idx = {eangle_i, {(SINE_INDEX_BITS-ANGLE_BITS){1'b0}}};
  end

  assign cos_idx = sin_idx + SINE_INDEX_BITS'(Q);

  logic [RAW-1:0]              sin_addr, cos_addr;
  logic signed [SINE_BITS-1:0] sin_d, cos_d;
  logic signed [SINE_BITS-1:0] sin2_q, cos2_q;

  always_comb begin
    sin_addr = sin_idx[QBITS] ? RAW'(Q) - RAW'(sin_idx[QBITS-1:0]) : RAW'(sin_idx[QBITS-1:0]);
    cos_addr = cos_idx[QBITS] ? RAW'(Q) - RAW'(cos_idx[QBITS-1:0]) : RAW'(cos_idx[QBITS-1:0]);
    sin_d    = sin_idx[QBITS+1] ? -signed'(rom[sin_addr]) : signed'(rom[sin_addr]);
    cos_d    = cos_idx[QBITS+1] ? -signed'(rom[cos_addr]) : signed'(rom[cos_addr]);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s2) begin
      sin2_q <= sin_d;
      cos2_q <= cos_d;
    end
  end

  assign sin2_o = sin2_q;
  assign cos2_o = cos2_q;

endmodule

`default_nettype wire

// ----- src/cpct_park.sv -----
`default_nettype none

module cpct_park
  import cpct_pkg::*;
#(
  parameter int CURRENT_BITS = 16
) (
  input  logic                                        clk_i,
  input  stage_ld_t                                   ld_i,
  input  logic signed [alpha_width(CURRENT_BITS)-1:0] alpha_i,
  input  logic signed [beta_width(CURRENT_BITS)-1:0]  beta_i,
  input  logic signed [SINE_BITS-1:0]                 sin_i,
  input  logic signed [SINE_BITS-1:0]                 cos_i,
  output logic signed [CURRENT_BITS-1:0]              d_current_o,
  output logic signed [CURRENT_BITS-1:0]              q_current_o,
  output logic                                        saturated_o
);

  localparam int AW   = alpha_width(CURRENT_BITS);
  localparam int BWW  = beta_width(CURRENT_BITS);
  localparam int PAW  = AW + SINE_BITS;
  localparam int PBW  = BWW + SINE_BITS;
  localparam int SUMW = PBW + 1;
  localparam int RW   = SUMW - 31;
  localparam logic signed [SUMW-1:0] ROUND_BIAS = {{(SUMW-31){1'b0}}, 1'b1, 30'b0};

  logic signed [PAW-1:0] p_ac3_q, p_as3_q;
  logic signed [PBW-1:0] p_bc3_q, p_bs3_q;

  always_ff @(posedge clk_i) begin
    if (ld_i.s3) begin
      p_ac3_q <= PAW'(alpha_i) * PAW'(cos_i);
      p_as3_q <= PAW'(alpha_i) * PAW'(sin_i);
      p_bc3_q <= PBW'(beta_i) * PBW'(cos_i);
      p_bs3_q <= PBW'(beta_i) * PBW'(sin_i);
    end
  end

  logic signed [SUMW-1:0]         d_sum, q_sum;
  logic [RW-1:0]                  d_rnd, q_rnd;
  logic                           d_fits, q_fits;
  logic signed [CURRENT_BITS-1:0] d_d, q_d;

  always_comb begin
    d_sum  = (SUMW'(p_ac3_q) <<< 16) + SUMW'(p_bs3_q) + ROUND_BIAS;
    q_sum  = SUMW'(p_bc3_q) - (SUMW'(p_as3_q) <<< 16) + ROUND_BIAS;
    d_rnd  = d_sum[SUMW-1:31];
    q_rnd  = q_sum[SUMW-1:31];
    d_fits = (d_rnd[RW-1:CURRENT_BITS-1] == '0) || (d_rnd[RW-1:CURRENT_BITS-1] == '1);
    q_fits = (q_rnd[RW-1:CURRENT_BITS-1] == '0) || (q_rnd[RW-1:CURRENT_BITS-1] == '1);
    d_d    = d_fits ? d_rnd[CURRENT_BITS-1:0]
                    : {d_rnd[RW-1], {(CURRENT_BITS-1){~d_rnd[RW-1]}}};
    q_d    = q_fits ? q_rnd[CURRENT_BITS-1:0]
                    : {q_rnd[RW-1], {(CURRENT_BITS-1){~q_rnd[RW-1]}}};
  end

  logic signed [CURRENT_BITS-1:0] d4_q, q4_q;
  logic                           sat4_q;

  always_ff @(posedge clk_i) begin
    if (ld_i.s4) begin
      d4_q   <= d_d;
      q4_q   <= q_d;
      sat4_q <= ~(d_fits & q_fits);
    end
  end

  assign d_current_o = d4_q;
  assign q_current_o = q4_q;
  assign saturated_o = sat4_q;

endmodule

`default_nettype wire

// ----- src/clarke_park_current_transform_unit.sv -----
// channel  dir  payload                                              handshake
// cfg_i    in   index, data (missing_phase, pole_count, reverse, offset) valid/ready
// in_i     in   ia/ib/ic_current, rotor_pos                           valid/ready
// out_o    out  d/q_current, electrical_angle, saturated              valid/ready
//
// four register stages: angle and phase rebuild, sine rom and beta scale,
// park products, round and saturate; one transfer per cycle unless the output stalls
// ready ripples back through the stage valid bits, so bubbles are squeezed out
// and a stalled output holds while earlier stages still fill
// reset clears the stage valid bits and loads the register defaults
// configuration writes are always accepted and take effect on the next transfer
`default_nettype none

module clarke_park_current_transform_unit
  import cpct_pkg::*;
#(
  parameter int SINE_INDEX_BITS = 10,
  parameter int CURRENT_BITS    = 16,
  parameter int ANGLE_BITS      = 16
) (
  input logic      clk_i,
  input logic      rst_ni,
  cpct_cfg_if.sink cfg_i,
  cpct_in_if.sink  in_i,
  cpct_out_if.source out_o
);

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.missing_phase     <= MISSING_PHASE_RST;
      cfg_q.pole_count        <= POLE_COUNT_RST;
      cfg_q.reverse_direction <= REVERSE_RST;
      cfg_q.zero_offset       <= ZERO_OFFSET_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_MISSING_PHASE:     cfg_q.missing_phase     <= phase_e'(cfg_i.data[1:0]);
        CFG_POLE_COUNT:        cfg_q.pole_count        <= cfg_i.data[6:0];
        CFG_REVERSE_DIRECTION: cfg_q.reverse_direction <= cfg_i.data[0];
        CFG_ZERO_OFFSET:       cfg_q.zero_offset       <= cfg_i.data;
        default: ;
      endcase
    end
  end

  logic [3:0] vld_q, vld_d;
  logic [3:0] stage_rdy;
  stage_ld_t  ld;

  always_comb begin
    stage_rdy[3] = !vld_q[3] || out_o.ready;
    stage_rdy[2] = !vld_q[2] || stage_rdy[3];
    stage_rdy[1] = !vld_q[1] || stage_rdy[2];
    stage_rdy[0] = !vld_q[0] || stage_rdy[1];
    ld.s1 = in_i.valid && stage_rdy[0];
    ld.s2 = vld_q[0] && stage_rdy[1];
    ld.s3 = vld_q[1] && stage_rdy[2];
    ld.s4 = vld_q[2] && stage_rdy[3];
    vld_d[0] = stage_rdy[0] ? in_i.valid : vld_q[0];
    vld_d[1] = stage_rdy[1] ? vld_q[0]   : vld_q[1];
    vld_d[2] = stage_rdy[2] ? vld_q[1]   : vld_q[2];
    vld_d[3] = stage_rdy[3] ? vld_q[2]   : vld_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_i.ready  = stage_rdy[0];
  assign out_o.valid = vld_q[3];

  logic [ANGLE_BITS-1:0]                       eangle1;
  logic signed [alpha_width(CURRENT_BITS)-1:0] alpha2;
  logic signed [beta_width(CURRENT_BITS)-1:0]  beta2;
  logic signed [SINE_BITS-1:0]                 sin2, cos2;

  cpct_angle #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_angle (
    .clk_i,
    .cfg_i      (cfg_q),
    .ld_i       (ld),
    .rotor_pos_i(in_i.rotor_pos),
    .eangle1_o  (eangle1),
    .eangle4_o  (out_o.electrical_angle)
  );

  cpct_clarke #(
    .CURRENT_BITS(CURRENT_BITS)
  ) u_clarke (
    .clk_i,
    .cfg_i       (cfg_q),
    .ld_i        (ld),
    .ia_current_i(in_i.ia_current),
    .ib_current_i(in_i.ib_current),
    .ic_current_i(in_i.ic_current),
    .alpha2_o    (alpha2),
    .beta2_o     (beta2)
  );

  cpct_sine #(
    .SINE_INDEX_BITS(SINE_INDEX_BITS),
    .ANGLE_BITS     (ANGLE_BITS)
  ) u_sine (
    .clk_i,
    .ld_i    (ld),
    .eangle_i(eangle1),
    .sin2_o  (sin2),
    .cos2_o  (cos2)
  );

  cpct_park #(
    .CURRENT_BITS(CURRENT_BITS)
  ) u_park (
    .clk_i,
    .ld_i       (ld),
    .alpha_i    (alpha2),
    .beta_i     (beta2),
    .sin_i      (sin2),
    .cos_i      (cos2),
    .d_current_o(out_o.d_current),
    .q_current_o(out_o.q_current),
    .saturated_o(out_o.saturated)
  );

endmodule

`default_nettype wire

// ----- src/cpct_checker.sv -----
`default_nettype none

module cpct_checker #(
  parameter int CURRENT_BITS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic signed [CURRENT_BITS-1:0] d_current_i,
  input logic signed [CURRENT_BITS-1:0] q_current_i,
  input logic [ANGLE_BITS-1:0]          electrical_angle_i,
  input logic                           saturated_i
);

  localparam logic signed [CURRENT_BITS-1:0] CUR_MAX = {1'b0, {(CURRENT_BITS-1){1'b1}}};
  localparam logic signed [CURRENT_BITS-1:0] CUR_MIN = {1'b1, {(CURRENT_BITS-1){1'b0}}};

  // the pipeline only backs up behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("input stalled while output is free");

  // clipping always lands on a rail
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && saturated_i) |->
      (d_current_i == CUR_MAX || d_current_i == CUR_MIN ||
       q_current_i == CUR_MAX || q_current_i == CUR_MIN))
    else $error("saturation flag without a clipped current");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      $stable({d_current_i, q_current_i, electrical_angle_i, saturated_i}))
    else $error("result changed while stalled");

endmodule

bind clarke_park_current_transform_unit cpct_checker #(
  .CURRENT_BITS(CURRENT_BITS),
  .ANGLE_BITS  (ANGLE_BITS)
) u_cpct_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .d_current_i       (out_o.d_current),
  .q_current_i       (out_o.q_current),
  .electrical_angle_i(out_o.electrical_angle),
  .saturated_i       (out_o.saturated)
);

`default_nettype wire

// ----- test/clarke_park_current_transform_unit_test.sv -----
`timescale 1ns / 100ps

module clarke_park_current_transform_unit_test;
  import cpct_pkg::*;

  localparam int CUR_BITS     = 16;
  localparam int ANG_BITS     = 16;
  localparam int SIN_IDX_BITS = 10;
  localparam int QUARTER      = 256;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 180;
  localparam int STALL_CYCLES = 400;

  localparam longint CUR_MAX    = 32767;
  localparam longint CUR_MIN    = -32768;
  localparam longint ROUND_HALF = 64'sd1073741824;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 4'd9;

  typedef struct packed {
    logic signed [CUR_BITS-1:0] ia;
    logic signed [CUR_BITS-1:0] ib;
    logic signed [CUR_BITS-1:0] ic;
    logic [ANG_BITS-1:0]        shaft;
  } phase_sample_t;

  typedef struct packed {
    logic signed [CUR_BITS-1:0] d;
    logic signed [CUR_BITS-1:0] q;
    logic [ANG_BITS-1:0]        angle;
    logic                       sat;
  } dq_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cpct_cfg_if cfg_ch ();
  cpct_in_if #(.CURRENT_BITS(CUR_BITS), .ANGLE_BITS(ANG_BITS)) smp_ch ();
  cpct_out_if #(.CURRENT_BITS(CUR_BITS), .ANGLE_BITS(ANG_BITS)) dq_ch ();

  clarke_park_current_transform_unit #(
    .SINE_INDEX_BITS(SIN_IDX_BITS),
    .CURRENT_BITS   (CUR_BITS),
    .ANGLE_BITS     (ANG_BITS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .in_i  (smp_ch),
    .out_o (dq_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor copy of the registers
  phase_e      missing_cfg    = MISSING_PHASE_RST;
  logic [6:0]  pole_count_cfg = POLE_COUNT_RST;
  logic        reverse_cfg    = REVERSE_RST;
  logic [15:0] offset_cfg     = ZERO_OFFSET_RST;

  longint sine_quarter [0:QUARTER];

  phase_sample_t sample_backlog [$];
  dq_result_t    dq_expected [$];

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int hold_left     = 0;
  bit in_taken      = 1'b0;

  int cycle_count     = 0;
  int samples_sent    = 0;
  int results_checked = 0;
  int sat_seen        = 0;
  int mismatches      = 0;
  int cfg_writes      = 0;

  function automatic longint quarter_wave(int j);
    longint unsigned x, x2, term, us;
    longint sum, r;
    int n;
    x = (HALF_PI_Q30 * longint'(j)) >> (SIN_IDX_BITS - 2);
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    us = sum;
    r = longint'((us * SINE_AMPLITUDE + 64'd536870912) >> 30);
    if (r > longint'(SINE_AMPLITUDE)) begin
      r = longint'(SINE_AMPLITUDE);
    end
    return r;
  endfunction

  function automatic longint sine_of(logic [SIN_IDX_BITS-1:0] idx);
    logic [1:0] quad;
    int j;
    quad = idx[SIN_IDX_BITS-1 -: 2];
    j = int'(idx[SIN_IDX_BITS-3:0]);
    case (quad)
      2'd0: return sine_quarter[j];
      2'd1: return sine_quarter[QUARTER - j];
      2'd2: return -sine_quarter[j];
      default: return -sine_quarter[QUARTER - j];
    endcase
  endfunction

  function automatic longint clip_current(longint v, inout logic sat);
    if (v > CUR_MAX) begin
      sat = 1'b1;
      return CUR_MAX;
    end
    if (v < CUR_MIN) begin
      sat = 1'b1;
      return CUR_MIN;
    end
    return v;
  endfunction

  function automatic dq_result_t transform_currents(phase_sample_t s);
    logic [ANG_BITS-1:0] shaft, eangle;
    logic [SIN_IDX_BITS-1:0] sidx;
    longint ia, ib, ic, beta_sum, alpha_w, beta_w, sn, cs, dv, qv;
    logic sat;
    dq_result_t r;
    shaft = s.shaft;
    if (reverse_cfg) begin
      shaft = ANG_BITS'(0 - shaft);
    end
    eangle = ANG_BITS'(shaft * pole_count_cfg - offset_cfg);
    sidx = eangle[ANG_BITS-1 -: SIN_IDX_BITS];
    sn = sine_of(sidx);
    cs = sine_of(SIN_IDX_BITS'(sidx + QUARTER));
    ia = longint'($signed(s.ia));
    ib = longint'($signed(s.ib));
    ic = longint'($signed(s.ic));
    case (missing_cfg)
      PHASE_A_MISSING: ia = -(ib + ic);
      PHASE_B_MISSING: ib = -(ia + ic);
      default: ;
    endcase
    if (missing_cfg == PHASE_ALL_SENSED) begin
      beta_sum = ib - ic;
    end else begin
      beta_sum = ia + 2 * ib;
    end
    alpha_w = ia * 65536;
    beta_w = beta_sum * longint'(INV_SQRT3_Q16);
    dv = (alpha_w * cs + beta_w * sn + ROUND_HALF) >>> 31;
    qv = (beta_w * cs - alpha_w * sn + ROUND_HALF) >>> 31;
    sat = 1'b0;
    dv = clip_current(dv, sat);
    qv = clip_current(qv, sat);
    r.d = CUR_BITS'(dv);
    r.q = CUR_BITS'(qv);
    r.angle = eangle;
    r.sat = sat;
    return r;
  endfunction

  // transfer sampling, prediction and checking
  always @(posedge clk_i) begin : watch_transfers
    dq_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, dq_expected.size());
      $display("clarke_park_current_transform_unit_test: FAIL");
      $finish;
    end
    in_taken = smp_ch.valid && smp_ch.ready;
    if (in_taken) begin
      dq_expected.push_back(transform_currents({smp_ch.ia_current, smp_ch.ib_current,
                                                smp_ch.ic_current, smp_ch.rotor_pos}));
      samples_sent++;
    end
    if (dq_ch.valid && dq_ch.ready) begin
      if (dq_expected.size() == 0) begin
        $display("%0t: unexpected result d %0d q %0d angle %0d sat %0b", $time,
                 dq_ch.d_current, dq_ch.q_current, dq_ch.electrical_angle, dq_ch.saturated);
        mismatches++;
      end else begin
        want = dq_expected.pop_front();
        results_checked++;
        if (want.sat) begin
          sat_seen++;
        end
        if (dq_ch.d_current !== want.d) begin
          $display("%0t: d_current expected %0d got %0d", $time, want.d, dq_ch.d_current);
          mismatches++;
        end
        if (dq_ch.q_current !== want.q) begin
          $display("%0t: q_current expected %0d got %0d", $time, want.q, dq_ch.q_current);
          mismatches++;
        end
        if (dq_ch.electrical_angle !== want.angle) begin
          $display("%0t: electrical_angle expected %0d got %0d", $time, want.angle,
                   dq_ch.electrical_angle);
          mismatches++;
        end
        if (dq_ch.saturated !== want.sat) begin
          $display("%0t: saturated expected %0b got %0b", $time, want.sat, dq_ch.saturated);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk_i) begin : drive_samples
    phase_sample_t nxt;
    if (rst_ni && (!smp_ch.valid || in_taken)) begin
      if (sample_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = sample_backlog.pop_front();
        smp_ch.valid      <= 1'b1;
        smp_ch.ia_current <= nxt.ia;
        smp_ch.ib_current <= nxt.ib;
        smp_ch.ic_current <= nxt.ic;
        smp_ch.rotor_pos  <= nxt.shaft;
      end else begin
        smp_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      dq_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      dq_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      dq_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic push_sample(int ia, int ib, int ic, int ang);
    phase_sample_t s;
    s.ia = CUR_BITS'(ia);
    s.ib = CUR_BITS'(ib);
    s.ic = CUR_BITS'(ic);
    s.shaft = ANG_BITS'(ang);
    sample_backlog.push_back(s);
  endtask

  function automatic int rand_current();
    case ($urandom_range(7))
      0: return -32768;
      1: return 32767;
      2: return int'($urandom_range(200)) - 100;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  function automatic int rand_angle();
    case ($urandom_range(7))
      0: return int'($urandom_range(3)) << 14;
      1: return 16'hFFFF;
      default: return int'(16'($urandom));
    endcase
  endfunction

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      CFG_MISSING_PHASE:     missing_cfg = phase_e'(val[1:0]);
      CFG_POLE_COUNT:        pole_count_cfg = val[6:0];
      CFG_REVERSE_DIRECTION: reverse_cfg = val[0];
      CFG_ZERO_OFFSET:       offset_cfg = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_config(logic [1:0] mp, logic [6:0] pp, logic rev, logic [15:0] off);
    write_reg(CFG_MISSING_PHASE, {14'($urandom), mp});
    write_reg(CFG_POLE_COUNT, {9'($urandom), pp});
    write_reg(CFG_REVERSE_DIRECTION, {15'($urandom), rev});
    write_reg(CFG_ZERO_OFFSET, off);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (sample_backlog.size() != 0 || smp_ch.valid) @(posedge clk_i);
    while (dq_expected.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : run_phases
    int k, n;
    logic [6:0] pp;
    for (k = 0; k <= QUARTER; k++) begin
      sine_quarter[k] = quarter_wave(k);
    end
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    smp_ch.valid = 1'b0;
    smp_ch.ia_current = '0;
    smp_ch.ib_current = '0;
    smp_ch.ic_current = '0;
    smp_ch.rotor_pos = '0;
    dq_ch.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, phase c rebuilt from a and b
    src_idle_pct = 38;
    sink_idle_pct = 66;
    push_sample(0, 0, 0, 0);
    push_sample(32767, 32767, 0, 0);
    push_sample(-32768, -32768, 32767, 16'h4000);
    push_sample(32767, -32768, -32768, 16'h8000);
    push_sample(-32768, 32767, 32767, 16'hC000);
    push_sample(0, 32767, 0, 16'hFFFF);
    push_sample(1, -1, 5, 16'h003F);
    push_sample(-1, 0, 0, 16'h0040);
    push_sample(16384, -8192, 0, 16'h3FC0);
    push_sample(-12345, 23456, 0, 16'h7FFF);
    drain();

    for (k = 0; k < PHASES; k++) begin
      if (k < 3) begin
        src_idle_pct = 38;
        sink_idle_pct = 66;
      end else if (k < 6) begin
        src_idle_pct = 66;
        sink_idle_pct = 38;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      case (k)
        0: begin
          set_config(PHASE_ALL_SENSED, 7'd64, 1'b0, 16'h0000);
          push_sample(32767, -32768, 32767, 16'h0400);
          push_sample(-32768, 32767, -32768, 16'hC000);
          push_sample(0, 32767, -32768, 16'h2000);
          push_sample(5, 0, 0, 16'h0000);
        end
        1: begin
          set_config(PHASE_A_MISSING, 7'd7, 1'b1, 16'h1234);
          push_sample(32767, -32768, -32768, 16'h1000);
          push_sample(-32768, 32767, 32767, 16'h9000);
          push_sample(0, 100, -50, 16'hFFFF);
        end
        2: begin
          set_config(PHASE_B_MISSING, 7'd0, 1'b0, 16'hFFFF);
          push_sample(-32768, 32767, -32768, 16'h5555);
          push_sample(32767, -32768, 32767, 16'hAAAA);
        end
        3: begin
          set_config(PHASE_C_MISSING, 7'd127, 1'b1, 16'($urandom));
          push_sample(-32768, 32767, 12, 16'h0001);
        end
        default: begin
          case ($urandom_range(3))
            0: pp = 7'd1;
            1: pp = 7'd64;
            2: pp = 7'($urandom_range(63, 1));
            default: pp = 7'($urandom);
          endcase
          set_config(2'($urandom_range(3)), pp, 1'($urandom), 16'($urandom));
          if (k == 5) begin
            write_reg(CFG_UNUSED_INDEX, 16'($urandom));
            @(negedge clk_i);
            cfg_ch.valid <= 1'b0;
          end
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        push_sample(rand_current(), rand_current(), rand_current(), rand_angle());
      end
      if (k == PHASES - 1) begin
        // long output stall while samples keep coming
        @(posedge clk_i);
        hold_left = STALL_CYCLES;
      end
      drain();
    end

    $display("%0d current samples over %0d register writes and %0d settings",
             samples_sent, cfg_writes, PHASES + 1);
    $display("%0d d/q results checked, %0d saturated, %0d mismatches",
             results_checked, sat_seen, mismatches);
    if (mismatches == 0 && dq_expected.size() == 0) begin
      $display("clarke_park_current_transform_unit_test: PASS");
    end else begin
      $display("clarke_park_current_transform_unit_test: FAIL");
    end
    $finish;
  end

endmodule
